[hdl/sita_pkg.sv]
// sita_pkg: shared types, constants and a helper function for the signed integer to ascii block
// depends on nothing; used by the interfaces and the top level
`timescale 1ns / 1ps
package sita_pkg;

  localparam int IN_W    = 16;
  localparam int BASE_W  = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd35;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIGIT,
    S_TERM
  } state_t;

  // digit value to its character: 0-9 then a-z
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + d_ext;
    end else begin
      return CHAR_A + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_DIGITS};
    end
  endfunction

endpackage

[hdl/sita_ifs.sv]
// sita_ifs: valid/ready channel interfaces for input values, output characters and base writes
// depends on sita_pkg for field widths
`timescale 1ns / 1ps

interface sita_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [sita_pkg::IN_W-1:0] signed_value;
  modport source (output valid, output signed_value, input ready);
  modport sink   (input valid, input signed_value, output ready);
endinterface

interface sita_out_if;
  logic                        valid;
  logic                        ready;
  logic [sita_pkg::CHAR_W-1:0] ascii_char;
  logic                        last_char;
  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

interface sita_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sita_pkg::BASE_W-1:0] number_base;
  modport source (output valid, output number_base, input ready);
  modport sink   (input valid, input number_base, output ready);
endinterface

[hdl/signed_integer_to_ascii_top.sv]
// signed_integer_to_ascii_top: converts a signed integer to ascii text in a base from 2 to 35
// depends on sita_pkg and the channel interfaces in sita_ifs.sv
`timescale 1ns / 1ps

// One value beat in gives a stream of character beats out: '-' for a negative value, the
// digits most significant first (0-9 then a-y), then a NUL beat with last_char set. A base
// outside 2..35 gives the NUL beat alone. The base register (reset 10) is written through
// the cfg channel, which is always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. Only the low VALUE_BITS bits of
// signed_value are converted. One value is handled at a time: each digit is the remainder
// of a full pass of the bit-serial restoring divider over the magnitude (one quotient bit
// per cycle through a narrow remainder register), then the beats go out one per cycle
// while out is ready. in is ready again the cycle after the NUL beat is taken.
module signed_integer_to_ascii_top #(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sita_in_if.sink     in_bus,
  sita_out_if.source  out_bus,
  sita_cfg_if.sink    cfg_bus
);

  localparam int MAG_BITS    = VALUE_BITS + 1;
  localparam int STORE_DEPTH = VALUE_BITS + 1;
  localparam int EXT_W       = (VALUE_BITS > sita_pkg::IN_W) ? VALUE_BITS : sita_pkg::IN_W;
  localparam int BIT_W       = $clog2(MAG_BITS);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DW          = sita_pkg::DIGIT_W;
  localparam int BW          = sita_pkg::BASE_W;
  localparam logic [MAG_BITS-1:0] MAG_TOP = {1'b1, {VALUE_BITS{1'b0}}};

  sita_pkg::state_t state_r, state_nxt;

  logic [BW-1:0]       base_r;
  logic [MAG_BITS-1:0] mag_r;      // dividend in, quotient out, one bit per cycle
  logic [DW-1:0]       rem_r;      // running remainder, always below the base
  logic [BIT_W-1:0]    bit_r;      // quotient bit position within one digit
  logic                qnz_r;      // some quotient bit of this digit was one
  logic [CNT_W-1:0]    cnt_r;      // digits still on the stack
  logic                neg_r;
  logic [DW-1:0]       stk_r [STORE_DEPTH];  // digit stack, top at entry 0

  // input value taken down to VALUE_BITS bits
  logic [EXT_W-1:0]      in_ext;
  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic [MAG_BITS-1:0]   mag_load;
  assign in_ext   = EXT_W'($unsigned(in_bus.signed_value));
  assign raw      = in_ext[VALUE_BITS-1:0];
  assign raw_neg  = raw[VALUE_BITS-1];
  assign mag_load = raw_neg ? (MAG_TOP - {1'b0, raw}) : {1'b0, raw};

  logic base_bad;
  assign base_bad = (base_r < sita_pkg::BASE_MIN) || (base_r > sita_pkg::BASE_MAX);

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_diff;
  logic          q_bit;
  logic [DW-1:0] rem_step;
  logic          digit_done;
  logic          quot_zero;
  assign rem_shift  = {rem_r, mag_r[MAG_BITS-1]};
  assign rem_diff   = rem_shift - {1'b0, base_r};
  assign q_bit      = (rem_shift >= {1'b0, base_r});
  assign rem_step   = q_bit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
  assign digit_done = (bit_r == BIT_W'(MAG_BITS - 1));
  assign quot_zero  = !(qnz_r || q_bit);

  logic in_beat, out_beat;
  assign in_beat  = in_bus.valid && in_bus.ready;
  assign out_beat = out_bus.valid && out_bus.ready;

  assign cfg_bus.ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sita_pkg::S_IDLE: begin
        if (in_beat) begin
          state_nxt = base_bad ? sita_pkg::S_TERM : sita_pkg::S_DIV;
        end
      end
      sita_pkg::S_DIV: begin
        if (digit_done && quot_zero) begin
          state_nxt = neg_r ? sita_pkg::S_SIGN : sita_pkg::S_DIGIT;
        end
      end
      sita_pkg::S_SIGN: begin
        if (out_beat) begin
          state_nxt = sita_pkg::S_DIGIT;
        end
      end
      sita_pkg::S_DIGIT: begin
        if (out_beat && (cnt_r == CNT_W'(1))) begin
          state_nxt = sita_pkg::S_TERM;
        end
      end
      sita_pkg::S_TERM: begin
        if (out_beat) begin
          state_nxt = sita_pkg::S_IDLE;
        end
      end
      default: state_nxt = sita_pkg::S_IDLE;
    endcase
  end

  // handshake and character outputs, all from registers
  always_comb begin
    in_bus.ready       = 1'b0;
    out_bus.valid      = 1'b0;
    out_bus.ascii_char = sita_pkg::CHAR_NUL;
    out_bus.last_char  = 1'b0;
    unique case (state_r)
      sita_pkg::S_IDLE: begin
        in_bus.ready = 1'b1;
      end
      sita_pkg::S_DIV: begin
        out_bus.valid = 1'b0;
      end
      sita_pkg::S_SIGN: begin
        out_bus.valid      = 1'b1;
        out_bus.ascii_char = sita_pkg::CHAR_MINUS;
      end
      sita_pkg::S_DIGIT: begin
        out_bus.valid      = 1'b1;
        out_bus.ascii_char = sita_pkg::digit_char(stk_r[0]);
      end
      sita_pkg::S_TERM: begin
        out_bus.valid      = 1'b1;
        out_bus.ascii_char = sita_pkg::CHAR_NUL;
        out_bus.last_char  = 1'b1;
      end
      default: begin
        out_bus.valid = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sita_pkg::S_IDLE;
      base_r  <= sita_pkg::BASE_RESET;
      bit_r   <= '0;
      qnz_r   <= 1'b0;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        base_r <= cfg_bus.number_base;
      end
      if (state_r == sita_pkg::S_IDLE) begin
        if (in_beat) begin
          bit_r <= '0;
          qnz_r <= 1'b0;
          cnt_r <= '0;
          neg_r <= raw_neg && !base_bad;
        end
      end else if (state_r == sita_pkg::S_DIV) begin
        if (digit_done) begin
          // digit finished: push it and restart on the quotient
          bit_r <= '0;
          qnz_r <= 1'b0;
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          bit_r <= bit_r + BIT_W'(1);
          qnz_r <= qnz_r || q_bit;
        end
      end else if ((state_r == sita_pkg::S_DIGIT) && out_beat) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // datapath: divider shift registers and digit stack
  always_ff @(posedge clk) begin
    if ((state_r == sita_pkg::S_IDLE) && in_beat) begin
      mag_r <= mag_load;
      rem_r <= '0;
    end else if (state_r == sita_pkg::S_DIV) begin
      mag_r <= {mag_r[MAG_BITS-2:0], q_bit};
      if (digit_done) begin
        rem_r    <= '0;
        stk_r[0] <= rem_step;
        for (int i = 1; i < STORE_DEPTH; i++) begin
          stk_r[i] <= stk_r[i-1];
        end
      end else begin
        rem_r <= rem_step;
      end
    end else if ((state_r == sita_pkg::S_DIGIT) && out_beat) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  // an accepted value always starts a division or goes straight to the terminator
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == sita_pkg::S_DIV) || (state_r == sita_pkg::S_TERM))
    else $error("accepted value did not start a conversion");

  // the running remainder stays below the base during division
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sita_pkg::S_DIV) |-> ({1'b0, rem_r} < {1'b0, base_r}))
    else $error("remainder reached the base");

  // digits are shown only while the stack holds some
  a_stack_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sita_pkg::S_DIGIT) |-> (cnt_r != '0))
    else $error("digit beat with an empty stack");

  // the terminator beat ends the conversion
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_bus.last_char) |=> (state_r == sita_pkg::S_IDLE))
    else $error("conversion continued after the terminator");

  // a bad base never produces a digit or a sign
  a_bad_base_term: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && base_bad) |=> (state_r == sita_pkg::S_TERM) && !neg_r)
    else $error("bad base did not go to the terminator");

endmodule

[tb/sita_char_checker.sv]
// sita_char_checker: watches the value, base and character channels of the
// integer to text block, predicts each character beat and compares it
// depends on sita_pkg and the channel interfaces in sita_ifs.sv
`timescale 1ns / 1ps

module sita_char_checker (
  input  logic clk,
  input  logic rst_n,
  sita_in_if   in_mon,
  sita_out_if  out_mon,
  sita_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_beats
);

  typedef struct packed {
    logic [sita_pkg::CHAR_W-1:0] ascii_char;
    logic                        last_char;
  } char_beat_t;

  string                       digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
  logic [sita_pkg::BASE_W-1:0] base_model = sita_pkg::BASE_RESET;
  char_beat_t                  expected_chars[$];
  int                          mismatches = 0;

  // spell one value in the current base and queue its characters
  function automatic void spell_value(input logic [sita_pkg::IN_W-1:0] value);
    logic [sita_pkg::DIGIT_W-1:0] digits [sita_pkg::IN_W+1];
    logic [sita_pkg::IN_W:0]      magnitude;
    logic [sita_pkg::IN_W:0]      radix;
    int                           n_digits;
    char_beat_t                   beat;
    if (base_model < sita_pkg::BASE_MIN || base_model > sita_pkg::BASE_MAX) begin
      beat.ascii_char = sita_pkg::CHAR_NUL;
      beat.last_char  = 1'b1;
      expected_chars.push_back(beat);
      return;
    end
    radix = {{(sita_pkg::IN_W+1-sita_pkg::BASE_W){1'b0}}, base_model};
    // one bit wider so the most negative value has a magnitude
    if (value[sita_pkg::IN_W-1]) begin
      magnitude = {1'b1, {sita_pkg::IN_W{1'b0}}} - {1'b0, value};
    end else begin
      magnitude = {1'b0, value};
    end
    n_digits = 0;
    do begin
      digits[n_digits] = sita_pkg::DIGIT_W'(magnitude % radix);
      magnitude = magnitude / radix;
      n_digits++;
    end while (magnitude != 0);
    beat.last_char = 1'b0;
    if (value[sita_pkg::IN_W-1]) begin
      beat.ascii_char = sita_pkg::CHAR_MINUS;
      expected_chars.push_back(beat);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      beat.ascii_char = digit_set.getc(int'(digits[i]));
      expected_chars.push_back(beat);
    end
    beat.ascii_char = sita_pkg::CHAR_NUL;
    beat.last_char  = 1'b1;
    expected_chars.push_back(beat);
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst_n) begin
      base_model = sita_pkg::BASE_RESET;
      expected_chars.delete();
    end else begin
      // a value beat uses the base held before this edge
      if (in_mon.valid && in_mon.ready) begin
        spell_value(in_mon.signed_value);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        base_model = cfg_mon.number_base;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_chars.size() == 0) begin
          $error("output beat with no character expected: ascii_char 8'h%h, last_char %b",
                 out_mon.ascii_char, out_mon.last_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.ascii_char !== want.ascii_char) begin
            $error("ascii_char mismatch: expected 8'h%h, actual 8'h%h",
                   want.ascii_char, out_mon.ascii_char);
            mismatches++;
          end
          if (out_mon.last_char !== want.last_char) begin
            $error("last_char mismatch: expected %b, actual %b",
                   want.last_char, out_mon.last_char);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_beats <= expected_chars.size();
  end

endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for signed_integer_to_ascii_top
// depends on sita_pkg, sita_ifs.sv, the block itself and sita_char_checker
`timescale 1ns / 1ps

module tb_top;

  // per item the block puts out at most 18 beats (base 2, most negative value),
  // and this limit covers the whole run with room to spare
  localparam int LIMIT_CYCLES    = 600000;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int BASE_HOLD       = 16;
  localparam int TAIL_CYCLES     = 20;

  // idle percentages per random phase: none, sender, receiver, both
  localparam int GAP_PLAN   [4] = '{0, 45, 0, 16};
  localparam int STALL_PLAN [4] = '{0, 0, 45, 16};

  logic clk;
  logic rst_n;
  int   gap_pct;
  int   stall_pct;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_beats;

  sita_in_if  in_if ();
  sita_out_if out_if ();
  sita_cfg_if cfg_if ();

  signed_integer_to_ascii_top #(
    .VALUE_BITS (sita_pkg::IN_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  sita_char_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // one value beat; called at a falling edge, returns at a falling edge with
  // valid still high so back-to-back beats never drop valid in between
  task automatic push_value(input logic [sita_pkg::IN_W-1:0] value);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.signed_value = value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every queued character has come out
  task automatic drain_text();
    in_if.valid = 1'b0;
    while (pending_beats != 0) @(negedge clk);
    // the block drops back to idle the cycle after the terminator beat is taken
    repeat (3) @(negedge clk);
  endtask

  // base write; only called while the block is idle
  task automatic program_base(input logic [sita_pkg::BASE_W-1:0] base);
    cfg_if.valid       = 1'b1;
    cfg_if.number_base = base;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // mostly full-range values, with some small ones, zero, minus one and the extremes
  function automatic logic [sita_pkg::IN_W-1:0] pick_value();
    logic [sita_pkg::IN_W-1:0] small_mag;
    small_mag = sita_pkg::IN_W'($urandom_range(40));
    case ($urandom_range(9))
      0, 1: begin
        return ($urandom_range(1) != 0) ? -small_mag : small_mag;
      end
      2: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          2:       return {1'b0, {(sita_pkg::IN_W-1){1'b1}}};
          default: return {1'b1, {(sita_pkg::IN_W-1){1'b0}}};
        endcase
      end
      default: return sita_pkg::IN_W'($urandom());
    endcase
  endfunction

  // usually a legal radix, sometimes one below or above the legal range
  function automatic logic [sita_pkg::BASE_W-1:0] pick_base();
    if ($urandom_range(99) < 80) begin
      return sita_pkg::BASE_W'($urandom_range(sita_pkg::BASE_MAX, sita_pkg::BASE_MIN));
    end else if ($urandom_range(1) != 0) begin
      return sita_pkg::BASE_W'($urandom_range(1, 0));
    end else begin
      return sita_pkg::BASE_W'($urandom_range(63, 36));
    end
  endfunction

  initial begin
    // every input known from time zero
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.signed_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.number_base = '0;
    gap_pct            = 0;
    stall_pct          = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset base 10 first, zero, sign handling, both extremes
    push_value(16'sd0);
    push_value(16'sd1);
    push_value(-16'sd1);
    push_value(16'sd32767);
    push_value(16'h8000);
    push_value(16'sd10);
    push_value(-16'sd12345);

    // base 2: longest digit strings, most negative gives 16 digits
    drain_text();
    program_base(sita_pkg::BASE_MIN);
    push_value(16'h8000);
    push_value(16'sd32767);
    push_value(-16'sd1);

    // top legal radix, digit 'y' and the wrap at the radix itself
    drain_text();
    program_base(sita_pkg::BASE_MAX);
    push_value(16'sd34);
    push_value(16'sd35);
    push_value(16'h8000);
    push_value(16'sd32767);

    drain_text();
    program_base(6'd16);
    push_value(16'hbeef);
    push_value(16'sd255);

    // out-of-range radix: terminator only, just above, zero, one, all ones
    drain_text();
    program_base(sita_pkg::BASE_MAX + 6'd1);
    push_value(16'sd5);
    drain_text();
    program_base(6'd0);
    push_value(-16'sd7);
    drain_text();
    program_base(6'd1);
    push_value(16'sd1);
    drain_text();
    program_base(6'h3f);
    push_value(16'h8000);

    // random phases; each base change also makes the sender wait for the
    // whole backlog to come out
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = GAP_PLAN[ph];
      stall_pct = STALL_PLAN[ph];
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % BASE_HOLD == 0) begin
          drain_text();
          program_base(pick_base());
        end
        push_value(pick_value());
      end
    end

    drain_text();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
